@@ sv/ttsched_pkg.sv @@
package ttsched_pkg;

   // table geometry
   localparam int NUM_SLOTS   = 8;
   localparam int TIME_WIDTH  = 16;
   localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // dispatch produces at most this many run beats per request
   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // fixed field widths
   localparam int OP_W        = 2;
   localparam int FIELD_T_W   = 16;
   localparam int IDX_W       = 3;
   localparam int SLOT_OUT_W  = 4;
   localparam int PEND_W      = 8;

   localparam logic [PEND_W-1:0] PEND_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 2'd0,
      OP_ADD      = 2'd1,
      OP_DELETE   = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // which response beat the datapath builds
   typedef enum logic [2:0] {
      RES_EMPTY,
      RES_ADDED,
      RES_FULL,
      RES_DELETED,
      RES_RUN_MID,
      RES_RUN_LAST
   } res_type;

   typedef struct packed {
      logic              load_in;
      logic [SLOT_W-1:0] idx;
      logic              write;
      logic              hold_load;
      logic              emit;
      res_type           res;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   cur_used;
      logic   cur_pend;
      logic   del_ok;
      logic   out_free;
   } status_type;

endpackage

@@ sv/ttsched_if.sv @@
interface ttsched_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] start_delay;
   logic [15:0] run_period;
   logic [2:0]  slot_index;

   modport source (output valid, op, start_delay, run_period, slot_index, input ready);
   modport sink   (input valid, op, start_delay, run_period, slot_index, output ready);
endinterface

interface ttsched_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] slot_out;
   logic       run_valid;
   logic       error_flag;
   logic       last;

   modport source (output valid, slot_out, run_valid, error_flag, last, input ready);
   modport sink   (input valid, slot_out, run_valid, error_flag, last, output ready);
endinterface

@@ sv/ttsched_ctrl.sv @@
module ttsched_ctrl
   import ttsched_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              hold_valid_ff, hold_valid_in;

   logic step;
   logic add_hit;
   logic take;
   logic at_end;

   assign at_end    = (idx_ff == SLOT_W'(NUM_SLOTS - 1));
   assign req_ready = (state_ff == ST_IDLE);

   // per-slot decision during the walk
   always_comb begin
      step    = 1'b0;
      add_hit = 1'b0;
      take    = 1'b0;
      if (state_ff == ST_WALK) begin
         case (status.op)
            OP_TICK: step = 1'b1;
            OP_ADD: begin
               if (!status.cur_used) begin
                  add_hit = status.out_free;
               end else begin
                  step = 1'b1;
               end
            end
            OP_DISPATCH: begin
               if (status.cur_pend && (n_ff < CNT_W'(MAX_RESULTS))) begin
                  if (!hold_valid_ff || status.out_free) begin
                     take = 1'b1;
                     step = 1'b1;
                  end
               end else begin
                  step = 1'b1;
               end
            end
            default: step = 1'b0;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (add_hit) begin
               state_in = ST_IDLE;
            end else if (status.op == OP_DELETE) begin
               state_in = ST_FINISH;
            end else if (step && at_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.idx       = idx_ff;
      cmd.res       = RES_EMPTY;
      idx_in        = idx_ff;
      n_in          = n_ff;
      hold_valid_in = hold_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in   = 1'b1;
               idx_in        = '0;
               n_in          = '0;
               hold_valid_in = 1'b0;
            end
         end
         ST_WALK: begin
            case (status.op)
               OP_TICK: cmd.write = 1'b1;
               OP_ADD: begin
                  if (add_hit) begin
                     cmd.write = 1'b1;
                     cmd.emit  = 1'b1;
                     cmd.res   = RES_ADDED;
                  end
               end
               OP_DISPATCH: begin
                  if (take) begin
                     cmd.write     = 1'b1;
                     cmd.hold_load = 1'b1;
                     cmd.emit      = hold_valid_ff;
                     cmd.res       = RES_RUN_MID;
                     n_in          = n_ff + CNT_W'(1);
                     hold_valid_in = 1'b1;
                  end
               end
               default: cmd.write = 1'b0;
            endcase
            if (step && !at_end) idx_in = idx_ff + SLOT_W'(1);
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               case (status.op)
                  OP_TICK: cmd.res = RES_EMPTY;
                  OP_ADD:  cmd.res = RES_FULL;
                  OP_DELETE: begin
                     cmd.res   = RES_DELETED;
                     cmd.write = status.del_ok;
                  end
                  default: cmd.res = hold_valid_ff ? RES_RUN_LAST : RES_EMPTY;
               endcase
            end
         end
         default: cmd.emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         n_ff          <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         n_ff          <= n_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

endmodule

@@ sv/ttsched_dp.sv @@
module ttsched_dp
   import ttsched_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [OP_W-1:0]       req_op,
   input  logic [FIELD_T_W-1:0]  req_start_delay,
   input  logic [FIELD_T_W-1:0]  req_run_period,
   input  logic [IDX_W-1:0]      req_slot_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SLOT_OUT_W-1:0] rsp_slot_out,
   output logic                  rsp_run_valid,
   output logic                  rsp_error_flag,
   output logic                  rsp_last
);

   // slot table
   logic                  used_ff   [NUM_SLOTS];
   logic [TIME_WIDTH-1:0] delay_ff  [NUM_SLOTS];
   logic [TIME_WIDTH-1:0] period_ff [NUM_SLOTS];
   logic [PEND_W-1:0]     pend_ff   [NUM_SLOTS];

   // latched request
   op_type                in_op_ff;
   logic [TIME_WIDTH-1:0] in_start_ff;
   logic [TIME_WIDTH-1:0] in_period_ff;
   logic [IDX_W-1:0]      in_idx_ff;

   logic [SLOT_W-1:0]     hold_slot_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [SLOT_OUT_W-1:0] out_slot_ff, out_slot_in;
   logic                  out_run_ff, out_run_in;
   logic                  out_err_ff, out_err_in;
   logic                  out_last_ff, out_last_in;

   logic [SLOT_W-1:0]     addr;
   logic                  cur_used;
   logic [TIME_WIDTH-1:0] cur_delay;
   logic [TIME_WIDTH-1:0] cur_period;
   logic [PEND_W-1:0]     cur_pend;
   logic                  del_ok;

   logic                  ent_used_in;
   logic [TIME_WIDTH-1:0] ent_delay_in;
   logic [TIME_WIDTH-1:0] ent_period_in;
   logic [PEND_W-1:0]     ent_pend_in;

   assign addr       = (in_op_ff == OP_DELETE) ? SLOT_W'(in_idx_ff) : cmd.idx;
   assign cur_used   = used_ff[addr];
   assign cur_delay  = delay_ff[addr];
   assign cur_period = period_ff[addr];
   assign cur_pend   = pend_ff[addr];
   assign del_ok     = (int'(in_idx_ff) < NUM_SLOTS);

   assign status.op       = in_op_ff;
   assign status.cur_used = cur_used;
   assign status.cur_pend = (cur_pend != '0);
   assign status.del_ok   = del_ok;
   assign status.out_free = !out_valid_ff || rsp_ready;

   // new contents of the addressed slot
   always_comb begin
      ent_used_in   = cur_used;
      ent_delay_in  = cur_delay;
      ent_period_in = cur_period;
      ent_pend_in   = cur_pend;
      unique case (in_op_ff)
         OP_TICK: begin
            if (cur_used) begin
               if (cur_delay == '0) begin
                  if (cur_pend != PEND_MAX) ent_pend_in = cur_pend + PEND_W'(1);
                  if (cur_period != '0) ent_delay_in = cur_period - TIME_WIDTH'(1);
               end else begin
                  ent_delay_in = cur_delay - TIME_WIDTH'(1);
               end
            end
         end
         OP_ADD: begin
            ent_used_in   = 1'b1;
            ent_delay_in  = in_start_ff;
            ent_period_in = in_period_ff;
            ent_pend_in   = '0;
         end
         OP_DELETE: begin
            ent_used_in   = 1'b0;
            ent_delay_in  = '0;
            ent_period_in = '0;
            ent_pend_in   = '0;
         end
         OP_DISPATCH: begin
            ent_pend_in = cur_pend - PEND_W'(1);
            // one-shot task leaves the table once run
            if (cur_period == '0) begin
               ent_used_in  = 1'b0;
               ent_delay_in = '0;
               ent_pend_in  = '0;
            end
         end
         default: ent_used_in = cur_used;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            used_ff[i]   <= 1'b0;
            delay_ff[i]  <= '0;
            period_ff[i] <= '0;
            pend_ff[i]   <= '0;
         end
      end else if (cmd.write) begin
         used_ff[addr]   <= ent_used_in;
         delay_ff[addr]  <= ent_delay_in;
         period_ff[addr] <= ent_period_in;
         pend_ff[addr]   <= ent_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_op_ff     <= op_type'(req_op);
         in_start_ff  <= TIME_WIDTH'(req_start_delay);
         in_period_ff <= TIME_WIDTH'(req_run_period);
         in_idx_ff    <= req_slot_index;
      end
      if (cmd.hold_load) hold_slot_ff <= cmd.idx;
   end

   // response beat
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_slot_in  = out_slot_ff;
      out_run_in   = out_run_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_slot_in  = SLOT_OUT_W'(NUM_SLOTS);
         out_run_in   = 1'b0;
         out_err_in   = 1'b0;
         out_last_in  = 1'b1;
         unique case (cmd.res)
            RES_EMPTY: out_last_in = 1'b1;
            RES_ADDED: out_slot_in = SLOT_OUT_W'(cmd.idx);
            RES_FULL:  out_err_in  = 1'b1;
            RES_DELETED: begin
               out_slot_in = SLOT_OUT_W'(in_idx_ff);
               out_err_in  = !del_ok;
            end
            RES_RUN_MID: begin
               out_slot_in = SLOT_OUT_W'(hold_slot_ff);
               out_run_in  = 1'b1;
               out_last_in = 1'b0;
            end
            RES_RUN_LAST: begin
               out_slot_in = SLOT_OUT_W'(hold_slot_ff);
               out_run_in  = 1'b1;
            end
            default: out_last_in = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_slot_ff <= out_slot_in;
      out_run_ff  <= out_run_in;
      out_err_ff  <= out_err_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_slot_out   = out_slot_ff;
   assign rsp_run_valid  = out_run_ff;
   assign rsp_error_flag = out_err_ff;
   assign rsp_last       = out_last_ff;

endmodule

@@ sv/time_triggered_task_scheduler_core.sv @@
// Time-triggered task scheduler. Keeps NUM_SLOTS task slots, each with an
// in-use mark, a down-counting delay, a period and a saturating count of
// pending runs. A request beat carries one of four operations: tick, add,
// delete or dispatch. Every request yields one response beat, except a
// dispatch, which yields one beat per slot with pending runs (at most
// MAX_RESULTS, in slot order), with last set on the final beat, or one
// empty beat with last set if no slot has pending runs. Tick, add and
// dispatch walk the slot table one slot per cycle through a single table
// port, except that a response beat that is not taken holds the walk of
// add or dispatch until the sink accepts it. Add stops at the first free
// slot, and delete goes straight to its response. Only one request is in
// flight; req_chan.ready is high while the block is idle.
module time_triggered_task_scheduler_core
   import ttsched_pkg::*;
(
   input logic          clock,
   input logic          reset,
   ttsched_req_if.sink   req_chan,
   ttsched_rsp_if.source rsp_chan
);

   cmd_type    cmd;     // controller -> datapath
   status_type status;  // datapath -> controller
   logic       req_ready;

   // sequencer: walks the table and decides which beats go out
   ttsched_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // slot table, request latch, run holding register and response register
   ttsched_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_chan.op),
      .req_start_delay (req_chan.start_delay),
      .req_run_period  (req_chan.run_period),
      .req_slot_index  (req_chan.slot_index),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_slot_out    (rsp_chan.slot_out),
      .rsp_run_valid   (rsp_chan.run_valid),
      .rsp_error_flag  (rsp_chan.error_flag),
      .rsp_last        (rsp_chan.last)
   );

endmodule
